[hdl/fcr_pkg.sv]
// ============================================================================
// fcr_pkg - framed command receiver package
// Widths, sync/end markers, parse phases, result record and CRC-16 byte step.
// ============================================================================
package fcr_pkg;

    localparam int BYTE_W = 8;
    localparam int WORD_W = 16;

    localparam logic [BYTE_W-1:0] SYNC1_BYTE = 8'hAA;
    localparam logic [BYTE_W-1:0] SYNC2_BYTE = 8'hBB;
    localparam logic [BYTE_W-1:0] END_BYTE   = 8'hED;

    localparam logic [WORD_W-1:0] CRC_INIT  = 16'hFFFF;
    localparam logic [WORD_W-1:0] CRC_POLY  = 16'hA001;
    localparam logic [WORD_W-1:0] MAX_LEN_RESET = 16'd256;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_FRAME   = 1'b1;

    typedef enum logic [3:0] {
        PH_SYNC1   = 4'd0,
        PH_SYNC2   = 4'd1,
        PH_CMD     = 4'd2,
        PH_LENH    = 4'd3,
        PH_LENL    = 4'd4,
        PH_PAYLOAD = 4'd5,
        PH_CRCH    = 4'd6,
        PH_CRCL    = 4'd7,
        PH_END     = 4'd8
    } phase_t;

    typedef struct packed {
        logic              result_kind;
        logic [BYTE_W-1:0] data_byte;
        logic [WORD_W-1:0] payload_index;
        logic [BYTE_W-1:0] frame_command;
        logic [WORD_W-1:0] frame_length;
        logic              crc_match;
        logic [WORD_W-1:0] computed_crc;
        logic [WORD_W-1:0] received_crc;
    } result_t;

    // one byte of CRC-16/Modbus, reflected, bit at a time
    function automatic logic [WORD_W-1:0] crc16_byte(input logic [WORD_W-1:0] crc_in,
                                                     input logic [BYTE_W-1:0] b);
        logic [WORD_W-1:0] c;
        c = crc_in ^ {{(WORD_W-BYTE_W){1'b0}}, b};
        for (int i = 0; i < BYTE_W; i++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

[hdl/fcr_if.sv]
// ============================================================================
// fcr_if - item channels
// Received byte channel and result channel, valid/ready handshake.
// ============================================================================
interface fcr_rx_if import fcr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface fcr_res_if import fcr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              result_kind;
    logic [BYTE_W-1:0] data_byte;
    logic [WORD_W-1:0] payload_index;
    logic [BYTE_W-1:0] frame_command;
    logic [WORD_W-1:0] frame_length;
    logic              crc_match;
    logic [WORD_W-1:0] computed_crc;
    logic [WORD_W-1:0] received_crc;

    modport source (output valid, output result_kind, output data_byte,
                    output payload_index, output frame_command, output frame_length,
                    output crc_match, output computed_crc, output received_crc,
                    input ready);
    modport sink   (input valid, input result_kind, input data_byte,
                    input payload_index, input frame_command, input frame_length,
                    input crc_match, input computed_crc, input received_crc,
                    output ready);
endinterface

[hdl/fcr_parser.sv]
// ============================================================================
// fcr_parser - frame parse state and running CRC
// Holds the parse state; works out next state and the result of one byte.
// ============================================================================
module fcr_parser import fcr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  logic [BYTE_W-1:0] byte_in,
    input  logic [WORD_W-1:0] max_len,
    output logic              has_res,
    output result_t           res
);

    phase_t            phase_reg,  phase_next;
    logic [WORD_W-1:0] length_reg, length_next;
    logic [WORD_W-1:0] seen_reg,   seen_next;
    logic [WORD_W-1:0] crc_reg,    crc_next;
    logic [BYTE_W-1:0] crc_hi_reg, crc_hi_next;
    logic [BYTE_W-1:0] crc_lo_reg, crc_lo_next;
    logic [BYTE_W-1:0] cmd_reg,    cmd_next;

    logic [WORD_W-1:0] crc_step;
    logic [WORD_W-1:0] len_full;
    logic [WORD_W-1:0] seen_inc;
    logic [WORD_W-1:0] rcv_crc;

    assign crc_step = crc16_byte(crc_reg, byte_in);
    assign len_full = {length_reg[WORD_W-1:BYTE_W], byte_in};
    assign seen_inc = seen_reg + 1'b1;
    assign rcv_crc  = {crc_hi_reg, crc_lo_reg};

    always_comb
    begin
        phase_next  = phase_reg;
        length_next = length_reg;
        seen_next   = seen_reg;
        crc_next    = crc_reg;
        crc_hi_next = crc_hi_reg;
        crc_lo_next = crc_lo_reg;
        cmd_next    = cmd_reg;
        has_res     = 1'b0;
        res         = '0;

        unique case (phase_reg)
            PH_SYNC2:
            begin
                if (byte_in == SYNC2_BYTE)
                begin
                    crc_next   = crc_step;
                    phase_next = PH_CMD;
                end
                else
                begin
                    phase_next = PH_SYNC1;
                end
            end
            PH_CMD:
            begin
                cmd_next   = byte_in;
                crc_next   = crc_step;
                phase_next = PH_LENH;
            end
            PH_LENH:
            begin
                length_next = {byte_in, {BYTE_W{1'b0}}};
                crc_next    = crc_step;
                phase_next  = PH_LENL;
            end
            PH_LENL:
            begin
                length_next = len_full;
                crc_next    = crc_step;
                if (len_full > max_len)
                begin
                    phase_next = PH_SYNC1;
                end
                else
                begin
                    seen_next  = '0;
                    phase_next = (len_full != '0) ? PH_PAYLOAD : PH_CRCH;
                end
            end
            PH_PAYLOAD:
            begin
                crc_next          = crc_step;
                has_res           = 1'b1;
                res.result_kind   = KIND_PAYLOAD;
                res.data_byte     = byte_in;
                res.payload_index = seen_reg;
                seen_next         = seen_inc;
                if (seen_inc >= length_reg)
                    phase_next = PH_CRCH;
            end
            PH_CRCH:
            begin
                crc_hi_next = byte_in;
                phase_next  = PH_CRCL;
            end
            PH_CRCL:
            begin
                crc_lo_next = byte_in;
                phase_next  = PH_END;
            end
            PH_END:
            begin
                phase_next = PH_SYNC1;
                if (byte_in == END_BYTE)
                begin
                    has_res           = 1'b1;
                    res.result_kind   = KIND_FRAME;
                    res.frame_command = cmd_reg;
                    res.frame_length  = length_reg;
                    res.crc_match     = (crc_reg == rcv_crc);
                    res.computed_crc  = crc_reg;
                    res.received_crc  = rcv_crc;
                end
            end
            default:
            begin
                phase_next = PH_SYNC1;
                if (byte_in == SYNC1_BYTE)
                begin
                    crc_next   = crc16_byte(CRC_INIT, byte_in);
                    phase_next = PH_SYNC2;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_SYNC1;
            length_reg <= '0;
            seen_reg   <= '0;
            crc_reg    <= CRC_INIT;
            crc_hi_reg <= '0;
            crc_lo_reg <= '0;
            cmd_reg    <= '0;
        end
        else if (fire)
        begin
            phase_reg  <= phase_next;
            length_reg <= length_next;
            seen_reg   <= seen_next;
            crc_reg    <= crc_next;
            crc_hi_reg <= crc_hi_next;
            crc_lo_reg <= crc_lo_next;
            cmd_reg    <= cmd_next;
        end
    end

endmodule

[hdl/fcr_out_stage.sv]
// ============================================================================
// fcr_out_stage - result register
// Holds one result item until the consumer takes it.
// ============================================================================
module fcr_out_stage import fcr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      load,
    input  result_t   res_in,
    output logic      free,
    fcr_res_if.source res
);

    logic    valid_reg;
    result_t data_reg;

    assign free = !valid_reg || res.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (free)
            valid_reg <= load;
    end

    always_ff @(posedge clk)
    begin
        if (free && load)
            data_reg <= res_in;
    end

    assign res.valid         = valid_reg;
    assign res.result_kind   = data_reg.result_kind;
    assign res.data_byte     = data_reg.data_byte;
    assign res.payload_index = data_reg.payload_index;
    assign res.frame_command = data_reg.frame_command;
    assign res.frame_length  = data_reg.frame_length;
    assign res.crc_match     = data_reg.crc_match;
    assign res.computed_crc  = data_reg.computed_crc;
    assign res.received_crc  = data_reg.received_crc;

endmodule

[hdl/framed_command_receiver_crc16_unit.sv]
// Path: an accepted byte is held in the input register, its result item in the result register.
// Throughput: one byte per cycle; the input register, the byte-wide CRC step
// and the result register set the figure; a stall on the result side holds
// only bytes that give a result.
// Reset: asynchronous, active low; parser hunts for the first sync byte,
// maximum payload length returns to 256, no item is held.
// ============================================================================
// framed_command_receiver_crc16_unit - framed command receiver
// Parses sync/command/length/payload/CRC/end frames and checks CRC-16/Modbus.
// ============================================================================
module framed_command_receiver_crc16_unit import fcr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [WORD_W-1:0] cfg_wr_data,
    fcr_rx_if.sink            rx,
    fcr_res_if.source         res
);

    logic [WORD_W-1:0] max_len_reg;
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              advance;
    logic              has_res;
    logic              out_free;
    result_t           res_comb;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_len_reg <= MAX_LEN_RESET;
        else if (cfg_wr_en)
            max_len_reg <= cfg_wr_data;
    end

    assign advance  = in_valid_reg && (!has_res || out_free);
    assign rx.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (rx.ready)
            in_valid_reg <= rx.valid;
    end

    always_ff @(posedge clk)
    begin
        if (rx.ready && rx.valid)
            in_byte_reg <= rx.rx_byte;
    end

    fcr_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (advance),
        .byte_in (in_byte_reg),
        .max_len (max_len_reg),
        .has_res (has_res),
        .res     (res_comb)
    );

    fcr_out_stage u_out (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (advance && has_res),
        .res_in (res_comb),
        .free   (out_free),
        .res    (res)
    );

endmodule

[hdl/fcr_checker.sv]
// ============================================================================
// fcr_checker - port-level checks
// Result field consistency and result channel behaviour.
// ============================================================================
module fcr_checker import fcr_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              res_valid,
    input logic              res_ready,
    input logic              result_kind,
    input logic [BYTE_W-1:0] data_byte,
    input logic [WORD_W-1:0] payload_index,
    input logic [BYTE_W-1:0] frame_command,
    input logic [WORD_W-1:0] frame_length,
    input logic              crc_match,
    input logic [WORD_W-1:0] computed_crc,
    input logic [WORD_W-1:0] received_crc
);

    a_no_result_in_reset: assert property (@(posedge clk) !rst_n |-> !res_valid)
        else $error("result valid during reset");

    a_payload_fields: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && result_kind == KIND_PAYLOAD |->
            frame_command == '0 && frame_length == '0 && !crc_match &&
            computed_crc == '0 && received_crc == '0)
        else $error("payload item carries frame fields");

    a_frame_fields: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && result_kind == KIND_FRAME |->
            data_byte == '0 && payload_index == '0 &&
            crc_match == (computed_crc == received_crc))
        else $error("frame item fields inconsistent");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(result_kind) &&
            $stable(data_byte) && $stable(payload_index) && $stable(computed_crc))
        else $error("stalled result item changed");

endmodule

bind framed_command_receiver_crc16_unit fcr_checker u_fcr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .res_valid     (res.valid),
    .res_ready     (res.ready),
    .result_kind   (res.result_kind),
    .data_byte     (res.data_byte),
    .payload_index (res.payload_index),
    .frame_command (res.frame_command),
    .frame_length  (res.frame_length),
    .crc_match     (res.crc_match),
    .computed_crc  (res.computed_crc),
    .received_crc  (res.received_crc)
);

[tb/sv/tb_framed_command_receiver_crc16_unit.sv]
`timescale 1ns / 100ps
// ============================================================================
// tb_framed_command_receiver_crc16_unit - framed command receiver testbench
// Feeds framed and corrupted byte streams through the receiver under random
// back-pressure on both channels (off in the third random-traffic phase). Payload and frame results are predicted by
// an in-bench frame parser with its own CRC-16/Modbus and checked in order.
// The maximum payload length is swept through several settings.
// ============================================================================
module tb_framed_command_receiver_crc16_unit;
    import fcr_pkg::*;

    localparam int RESULT_LATENCY = 2;
    localparam int DRAIN_LIMIT    = 20000;

    logic              clk;
    logic              rst_n;
    logic              cfg_wr_en;
    logic [WORD_W-1:0] cfg_wr_data;

    fcr_rx_if  rx_if();
    fcr_res_if res_if();

    framed_command_receiver_crc16_unit i_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .rx          (rx_if),
        .res         (res_if)
    );

    // parser mirror
    logic [WORD_W-1:0] max_len_cfg   = MAX_LEN_RESET;
    phase_t            rx_phase      = PH_SYNC1;
    logic [WORD_W-1:0] hdr_length    = '0;
    logic [WORD_W-1:0] payload_count = '0;
    logic [WORD_W-1:0] crc_acc       = CRC_INIT;
    logic [BYTE_W-1:0] crc_hi_rx     = '0;
    logic [BYTE_W-1:0] crc_lo_rx     = '0;
    logic [BYTE_W-1:0] hdr_command   = '0;

    result_t results_due[$];
    int      error_count = 0;
    int      bytes_sent  = 0;
    logic    idling_on   = 1'b1;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    function automatic logic [WORD_W-1:0] crc16_modbus_step(input logic [WORD_W-1:0] c,
                                                            input logic [BYTE_W-1:0] d);
        logic [WORD_W-1:0] acc;
        acc = c ^ {8'h00, d};
        repeat (BYTE_W)
            acc = {1'b0, acc[WORD_W-1:1]} ^ (acc[0] ? CRC_POLY : '0);
        return acc;
    endfunction

    task automatic parse_rx_byte(input logic [BYTE_W-1:0] b);
        result_t r;
        r = '0;
        unique case (rx_phase)
            PH_SYNC2:
            begin
                if (b == SYNC2_BYTE)
                begin
                    crc_acc  = crc16_modbus_step(crc_acc, b);
                    rx_phase = PH_CMD;
                end
                else
                begin
                    rx_phase = PH_SYNC1;
                end
            end
            PH_CMD:
            begin
                hdr_command = b;
                crc_acc     = crc16_modbus_step(crc_acc, b);
                rx_phase    = PH_LENH;
            end
            PH_LENH:
            begin
                hdr_length = {b, 8'h00};
                crc_acc    = crc16_modbus_step(crc_acc, b);
                rx_phase   = PH_LENL;
            end
            PH_LENL:
            begin
                hdr_length[7:0] = b;
                crc_acc         = crc16_modbus_step(crc_acc, b);
                if (hdr_length > max_len_cfg)
                begin
                    rx_phase = PH_SYNC1;
                end
                else
                begin
                    payload_count = '0;
                    rx_phase      = (hdr_length != 0) ? PH_PAYLOAD : PH_CRCH;
                end
            end
            PH_PAYLOAD:
            begin
                crc_acc         = crc16_modbus_step(crc_acc, b);
                r.result_kind   = KIND_PAYLOAD;
                r.data_byte     = b;
                r.payload_index = payload_count;
                results_due.push_back(r);
                payload_count = payload_count + 1'b1;
                if (payload_count >= hdr_length)
                    rx_phase = PH_CRCH;
            end
            PH_CRCH:
            begin
                crc_hi_rx = b;
                rx_phase  = PH_CRCL;
            end
            PH_CRCL:
            begin
                crc_lo_rx = b;
                rx_phase  = PH_END;
            end
            PH_END:
            begin
                rx_phase = PH_SYNC1;
                if (b == END_BYTE)
                begin
                    r.result_kind   = KIND_FRAME;
                    r.frame_command = hdr_command;
                    r.frame_length  = hdr_length;
                    r.computed_crc  = crc_acc;
                    r.received_crc  = {crc_hi_rx, crc_lo_rx};
                    r.crc_match     = (crc_acc == {crc_hi_rx, crc_lo_rx});
                    results_due.push_back(r);
                end
            end
            default:
            begin
                rx_phase = PH_SYNC1;
                if (b == SYNC1_BYTE)
                begin
                    crc_acc  = crc16_modbus_step(CRC_INIT, b);
                    rx_phase = PH_SYNC2;
                end
            end
        endcase
    endtask

    task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                   input logic [WORD_W-1:0] want);
        $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // result sink: random stalls, in-order check
    initial
    begin
        result_t got;
        result_t want;
        res_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_if.valid && res_if.ready)
            begin
                got.result_kind   = res_if.result_kind;
                got.data_byte     = res_if.data_byte;
                got.payload_index = res_if.payload_index;
                got.frame_command = res_if.frame_command;
                got.frame_length  = res_if.frame_length;
                got.crc_match     = res_if.crc_match;
                got.computed_crc  = res_if.computed_crc;
                got.received_crc  = res_if.received_crc;
                if (results_due.size() == 0)
                begin
                    report_mismatch("unexpected item", {15'd0, got.result_kind}, '0);
                end
                else
                begin
                    want = results_due.pop_front();
                    if (got.result_kind !== want.result_kind)
                        report_mismatch("result_kind", 16'(got.result_kind),
                                        16'(want.result_kind));
                    if (got.data_byte !== want.data_byte)
                        report_mismatch("data_byte", 16'(got.data_byte), 16'(want.data_byte));
                    if (got.payload_index !== want.payload_index)
                        report_mismatch("payload_index", got.payload_index,
                                        want.payload_index);
                    if (got.frame_command !== want.frame_command)
                        report_mismatch("frame_command", 16'(got.frame_command),
                                        16'(want.frame_command));
                    if (got.frame_length !== want.frame_length)
                        report_mismatch("frame_length", got.frame_length, want.frame_length);
                    if (got.crc_match !== want.crc_match)
                        report_mismatch("crc_match", 16'(got.crc_match), 16'(want.crc_match));
                    if (got.computed_crc !== want.computed_crc)
                        report_mismatch("computed_crc", got.computed_crc, want.computed_crc);
                    if (got.received_crc !== want.received_crc)
                        report_mismatch("received_crc", got.received_crc, want.received_crc);
                end
            end
            res_if.ready <= idling_on ? ($urandom_range(0, 99) >= 32) : 1'b1;
        end
    end

    task automatic send_rx_byte(input logic [BYTE_W-1:0] b);
        while (idling_on && $urandom_range(0, 99) < 32)
        begin
            rx_if.valid <= 1'b0;
            @(posedge clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        @(posedge clk);
        while (!rx_if.ready)
            @(posedge clk);
        parse_rx_byte(b);
        bytes_sent++;
    endtask

    task automatic send_counted(input logic [BYTE_W-1:0] b, ref logic [WORD_W-1:0] crc);
        crc = crc16_modbus_step(crc, b);
        send_rx_byte(b);
    endtask

    task automatic send_header(input logic [BYTE_W-1:0] cmd, input logic [WORD_W-1:0] len,
                               ref logic [WORD_W-1:0] crc);
        crc = CRC_INIT;
        send_counted(SYNC1_BYTE, crc);
        send_counted(SYNC2_BYTE, crc);
        send_counted(cmd, crc);
        send_counted(len[15:8], crc);
        send_counted(len[7:0], crc);
    endtask

    task automatic send_frame(input logic [BYTE_W-1:0] cmd, input logic [WORD_W-1:0] len,
                              input logic crc_ok, input logic [BYTE_W-1:0] end_byte);
        logic [WORD_W-1:0] crc;
        logic [WORD_W-1:0] sent_crc;
        send_header(cmd, len, crc);
        for (int i = 0; i < len; i++)
            send_counted(8'($urandom), crc);
        sent_crc = crc_ok ? crc : crc ^ 16'($urandom_range(1, 16'hFFFF));
        send_rx_byte(sent_crc[15:8]);
        send_rx_byte(sent_crc[7:0]);
        send_rx_byte(end_byte);
    endtask

    task automatic wait_results_drained;
        int waited;
        waited = 0;
        rx_if.valid <= 1'b0;
        while (results_due.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (RESULT_LATENCY + 2) @(posedge clk);
    endtask

    task automatic set_max_payload_length(input logic [WORD_W-1:0] v);
        wait_results_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        max_len_cfg = v;
    endtask

    // bad second sync, over-long header, bad end, empty frame
    task automatic test_framing_errors;
        logic [WORD_W-1:0] crc;
        send_rx_byte(SYNC1_BYTE);
        send_rx_byte(SYNC1_BYTE);
        send_rx_byte(SYNC2_BYTE);
        send_header(8'h00, MAX_LEN_RESET + 1'b1, crc);
        send_frame(8'hFF, 16'd0, 1'b1, END_BYTE);
        send_frame(8'h00, 16'd0, 1'b1, 8'h00);
    endtask

    task automatic test_length_limits;
        logic [WORD_W-1:0] crc;
        set_max_payload_length(16'd0);
        send_header(8'h11, 16'd1, crc);
        send_frame(8'h22, 16'd0, 1'b1, END_BYTE);
        set_max_payload_length(16'hFFFE);
        send_header(8'h33, 16'hFFFF, crc);
        set_max_payload_length(16'hFFFF);
        send_frame(8'h44, 16'd260, 1'b1, END_BYTE);
        set_max_payload_length(MAX_LEN_RESET);
        send_frame(8'h55, MAX_LEN_RESET, 1'b0, END_BYTE);
    endtask

    task automatic test_random_traffic;
        logic [WORD_W-1:0] limits [4];
        int                phase_end;
        int                pick;
        int                cap;
        logic [WORD_W-1:0] len;
        limits[0] = 16'd3;
        limits[1] = 16'd20;
        limits[2] = 16'hFFFF;
        limits[3] = MAX_LEN_RESET;
        for (int p = 0; p < 4; p++)
        begin
            set_max_payload_length(limits[p]);
            idling_on = (p != 2);
            phase_end = bytes_sent + 80;
            cap = (limits[p] < 22) ? limits[p] + 2 : 24;
            while (bytes_sent < phase_end)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 80)
                begin
                    len = 16'($urandom_range(0, cap));
                    send_frame(8'($urandom), len, $urandom_range(0, 99) < 80,
                               ($urandom_range(0, 99) < 90) ? END_BYTE : 8'($urandom));
                end
                else if (pick < 90)
                begin
                    repeat ($urandom_range(1, 6))
                        send_rx_byte(8'($urandom));
                end
                else
                begin
                    send_rx_byte(SYNC1_BYTE);
                    send_rx_byte(8'($urandom_range(0, 8'hBA)));
                end
            end
        end
        idling_on = 1'b1;
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        cfg_wr_en     <= 1'b0;
        cfg_wr_data   <= '0;
        rx_if.valid   <= 1'b0;
        rx_if.rx_byte <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_framing_errors();
        test_length_limits();
        test_random_traffic();

        wait_results_drained();
        if (results_due.size() != 0)
            report_mismatch("items never produced", 16'(results_due.size()), '0);
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
